@@ sv/arpc_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// arpc_pkg
// Shared constants, codes and controller/datapath interface types for the
// ARP cache responder.
// ---------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF = 16;

  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned CFG_W  = 48;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'd1;

  // result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_TRUNC  = 2'd1;
  localparam logic [1:0] STATUS_UNSUPP = 2'd2;

  // item kinds
  localparam logic OP_FRAME   = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // frame field values
  localparam logic [LEN_W-1:0] MIN_ARP_LEN  = 11'd28;
  localparam logic [15:0]      HTYPE_ETH    = 16'h0001;
  localparam logic [15:0]      PTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]       HLEN_ETH     = 8'd6;
  localparam logic [7:0]       PLEN_IPV4    = 8'd4;
  localparam logic [15:0]      ARP_OP_REQ   = 16'h0001;
  localparam logic [MAC_W-1:0] MAC_BCAST    = '1;

  typedef struct packed {
    logic load;  // capture request, restart scan
    logic scan;  // read one cache entry
    logic fin;   // update cache, register result
  } arpc_cmd_t;

  typedef struct packed {
    logic scan_last;  // last entry address being read
  } arpc_stat_t;

endpackage

`default_nettype wire

@@ sv/arp_cache_responder.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// arp_cache_responder
// ARP responder with a small address cache: learns senders, answers
// requests for the own address and resolves addresses from the cache.
// ---------------------------------------------------------------------------
// A request is captured, the cache walked once and the compare stage drained;
// the result strobe is registered from the commit step. A new request is only
// taken when idle, as the single read port of the cache is walked per request.
// Reset: the cache comes up empty (valid bits cleared at once), own IP zero.
// The result is presented for one cycle; the receiver cannot stall it.
module arp_cache_responder #(
  parameter int unsigned CacheEntries = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire                            cfg_we_i,
  input  wire [arpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [arpc_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire                            operation_i,
  input  wire [arpc_pkg::LEN_W-1:0]      frame_length_i,
  input  wire [15:0]                     hw_type_i,
  input  wire [15:0]                     proto_type_i,
  input  wire [7:0]                      hw_len_i,
  input  wire [7:0]                      proto_len_i,
  input  wire [15:0]                     arp_oper_i,
  input  wire [arpc_pkg::IP_W-1:0]       sender_ip_i,
  input  wire [arpc_pkg::MAC_W-1:0]      sender_hw_i,
  input  wire [arpc_pkg::IP_W-1:0]       target_ip_i,
  input  wire [arpc_pkg::MAC_W-1:0]      src_mac_i,
  input  wire [arpc_pkg::TICK_W-1:0]     now_tick_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic                           hit_o,
  output logic [arpc_pkg::MAC_W-1:0]     resolved_mac_o,
  output logic                           send_valid_o,
  output logic                           send_is_reply_o,
  output logic [arpc_pkg::MAC_W-1:0]     send_dest_mac_o,
  output logic [arpc_pkg::MAC_W-1:0]     send_target_mac_o,
  output logic [arpc_pkg::IP_W-1:0]      send_target_ip_o
);
  import arpc_pkg::*;

  arpc_cmd_t  cmd;
  arpc_stat_t stat;

  arpc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  arpc_dp #(
    .CacheEntries (CacheEntries)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .operation_i       (operation_i),
    .frame_length_i    (frame_length_i),
    .hw_type_i         (hw_type_i),
    .proto_type_i      (proto_type_i),
    .hw_len_i          (hw_len_i),
    .proto_len_i       (proto_len_i),
    .arp_oper_i        (arp_oper_i),
    .sender_ip_i       (sender_ip_i),
    .sender_hw_i       (sender_hw_i),
    .target_ip_i       (target_ip_i),
    .src_mac_i         (src_mac_i),
    .now_tick_i        (now_tick_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .hit_o             (hit_o),
    .resolved_mac_o    (resolved_mac_o),
    .send_valid_o      (send_valid_o),
    .send_is_reply_o   (send_is_reply_o),
    .send_dest_mac_o   (send_dest_mac_o),
    .send_target_mac_o (send_target_mac_o),
    .send_target_ip_o  (send_target_ip_o)
  );

`ifndef SYNTHESIS
  // a result only follows the commit step, and the block is free again then
  a_done_after_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(cmd.fin) && !busy))
    else $error("result strobe without commit");

  // a captured request always keeps the block busy for the scan
  a_load_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> busy)
    else $error("request captured but block not busy");

  // a hit never asks for a frame to be sent
  a_hit_no_send : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> !send_valid_o)
    else $error("hit together with send request");

  // a dropped frame sends nothing and reports no hit
  a_drop_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STATUS_OK)) |-> (!send_valid_o && !hit_o))
    else $error("dropped frame produced output");
`endif

endmodule

`default_nettype wire

@@ sv/arpc_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: capture, one pass over the cache, drain the compare stage,
// then commit the update and the result.
// ---------------------------------------------------------------------------
module arpc_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  wire arpc_pkg::arpc_stat_t stat_i,
  output arpc_pkg::arpc_cmd_t   cmd_o,
  output logic                  busy_o
);
  import arpc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.scan = 1'b0;
    cmd_o.fin  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_FIN;
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

@@ sv/arpc_dp.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// arpc_dp
// Datapath: request capture, cache memory with per-entry valid bits,
// scan compare stage (match, first free, oldest) and result register.
// ---------------------------------------------------------------------------
module arpc_dp #(
  parameter int unsigned CacheEntries = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire arpc_pkg::arpc_cmd_t       cmd_i,
  output arpc_pkg::arpc_stat_t           stat_o,
  input  wire                            cfg_we_i,
  input  wire [arpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [arpc_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire                            operation_i,
  input  wire [arpc_pkg::LEN_W-1:0]      frame_length_i,
  input  wire [15:0]                     hw_type_i,
  input  wire [15:0]                     proto_type_i,
  input  wire [7:0]                      hw_len_i,
  input  wire [7:0]                      proto_len_i,
  input  wire [15:0]                     arp_oper_i,
  input  wire [arpc_pkg::IP_W-1:0]       sender_ip_i,
  input  wire [arpc_pkg::MAC_W-1:0]      sender_hw_i,
  input  wire [arpc_pkg::IP_W-1:0]       target_ip_i,
  input  wire [arpc_pkg::MAC_W-1:0]      src_mac_i,
  input  wire [arpc_pkg::TICK_W-1:0]     now_tick_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic                           hit_o,
  output logic [arpc_pkg::MAC_W-1:0]     resolved_mac_o,
  output logic                           send_valid_o,
  output logic                           send_is_reply_o,
  output logic [arpc_pkg::MAC_W-1:0]     send_dest_mac_o,
  output logic [arpc_pkg::MAC_W-1:0]     send_target_mac_o,
  output logic [arpc_pkg::IP_W-1:0]      send_target_ip_o
);
  import arpc_pkg::*;

  localparam int unsigned IdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int unsigned EntW = IP_W + TICK_W + MAC_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CacheEntries - 1);

  // configuration; own_mac is the sender address of the frame builder
  // downstream and nothing here depends on it
  logic [IP_W-1:0] own_ip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == REG_OWN_IP)) begin
      own_ip_q <= cfg_wdata_i[IP_W-1:0];
    end
  end

  // captured request
  logic              op_q;
  logic [LEN_W-1:0]  flen_q;
  logic [15:0]       htype_q, ptype_q, aop_q;
  logic [7:0]        hlen_q, plen_q;
  logic [IP_W-1:0]   sip_q, tip_q;
  logic [MAC_W-1:0]  shw_q, smac_q;
  logic [TICK_W-1:0] tick_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      flen_q  <= frame_length_i;
      htype_q <= hw_type_i;
      ptype_q <= proto_type_i;
      hlen_q  <= hw_len_i;
      plen_q  <= proto_len_i;
      aop_q   <= arp_oper_i;
      sip_q   <= sender_ip_i;
      shw_q   <= sender_hw_i;
      tip_q   <= target_ip_i;
      smac_q  <= src_mac_i;
      tick_q  <= now_tick_i;
    end
  end

  // scan address
  logic [IdxW-1:0] rd_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else if (cmd_i.load) begin
      rd_idx_q <= '0;
    end else if (cmd_i.scan) begin
      rd_idx_q <= rd_idx_q + 1'b1;
    end
  end

  assign stat_o.scan_last = (rd_idx_q == LastIdx);

  // cache store: {ip, tick, mac}; an entry without its valid bit reads as
  // free with tick zero
  logic [EntW-1:0]         mem_q [CacheEntries];
  logic [CacheEntries-1:0] valid_q;
  logic [EntW-1:0]         rdata_q;
  logic                    rvld_q;
  logic                    pend_q;
  logic [IdxW-1:0]         pend_idx_q;

  logic                    wr_en;
  logic [IdxW-1:0]         wr_idx;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx] <= {sip_q, tick_q, smac_q};
    if (cmd_i.scan) begin
      rdata_q    <= mem_q[rd_idx_q];
      rvld_q     <= valid_q[rd_idx_q];
      pend_idx_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      pend_q <= cmd_i.scan;
      if (wr_en) valid_q[wr_idx] <= 1'b1;
    end
  end

  // compare stage
  logic [IP_W-1:0]   ent_ip;
  logic [TICK_W-1:0] ent_tick;
  logic [MAC_W-1:0]  ent_mac;
  logic [IP_W-1:0]   key;
  logic              ent_match;

  assign ent_ip   = rvld_q ? rdata_q[EntW-1 -: IP_W] : '0;
  assign ent_tick = rvld_q ? rdata_q[MAC_W +: TICK_W] : '0;
  assign ent_mac  = rdata_q[MAC_W-1:0];
  assign key      = (op_q == OP_RESOLVE) ? tip_q : sip_q;
  // address zero never matches, free slots included
  assign ent_match = (ent_ip == key) && (key != '0);

  logic              match_q, free_q;
  logic [IdxW-1:0]   match_idx_q, free_idx_q, old_idx_q;
  logic [TICK_W-1:0] old_tick_q;
  logic [MAC_W-1:0]  match_mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (cmd_i.load) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (pend_q) begin
      if (ent_match) match_q <= 1'b1;
      if (ent_ip == '0) free_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      if (ent_match && !match_q) begin
        match_idx_q <= pend_idx_q;
        match_mac_q <= ent_mac;
      end
      if ((ent_ip == '0) && !free_q) free_idx_q <= pend_idx_q;
      // strict less-than keeps the lowest index on ties
      if ((pend_idx_q == '0) || (ent_tick < old_tick_q)) begin
        old_tick_q <= ent_tick;
        old_idx_q  <= pend_idx_q;
      end
    end
  end

  // request decode
  logic trunc, unsupp, frame_ok, reply, miss, hit;

  assign trunc    = (flen_q < MIN_ARP_LEN);
  assign unsupp   = (htype_q != HTYPE_ETH) || (ptype_q != PTYPE_IPV4) ||
                    (hlen_q != HLEN_ETH) || (plen_q != PLEN_IPV4);
  assign frame_ok = (op_q == OP_FRAME) && !trunc && !unsupp;
  assign reply    = frame_ok && (aop_q == ARP_OP_REQ) && (tip_q == own_ip_q);
  assign hit      = (op_q == OP_RESOLVE) && match_q;
  assign miss     = (op_q == OP_RESOLVE) && !match_q;

  assign wr_en  = cmd_i.fin && frame_ok && (sip_q != '0);
  assign wr_idx = match_q ? match_idx_q : (free_q ? free_idx_q : old_idx_q);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= cmd_i.fin;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (op_q == OP_RESOLVE) status_o <= STATUS_OK;
      else if (trunc)         status_o <= STATUS_TRUNC;
      else if (unsupp)        status_o <= STATUS_UNSUPP;
      else                    status_o <= STATUS_OK;
      hit_o             <= hit;
      resolved_mac_o    <= hit ? match_mac_q : '0;
      send_valid_o      <= reply || miss;
      send_is_reply_o   <= reply;
      send_dest_mac_o   <= reply ? smac_q : (miss ? MAC_BCAST : '0);
      send_target_mac_o <= reply ? shw_q : '0;
      send_target_ip_o  <= reply ? sip_q : (miss ? tip_q : '0);
    end
  end

endmodule

`default_nettype wire
